>>> rtl/core/assert_macros.svh
// Assertion macros shared by the rational approximation core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CFRA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CFRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/cfra_pkg.sv
// Types and constants of the continued-fraction rational approximation core.
package cfra_pkg;

   localparam int unsigned NUM_W       = 48;  // numerator width
   localparam int unsigned DEN_W       = 31;  // denominator and limit width
   localparam int unsigned TERM_W      = 31;  // largest term is 2^TERM_W - 1
   localparam int unsigned CHUNK_W     = 16;  // numerator slice per partial product
   localparam int unsigned N_CHUNKS    = NUM_W / CHUNK_W;
   localparam int unsigned CHUNK_IDX_W = 2;
   localparam int unsigned SH_W        = $clog2(NUM_W);

   localparam logic [DEN_W-1:0] DEN_RESET = DEN_W'(10000);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL_D,
      ST_CHK_D,
      ST_MUL_N,
      ST_UPDATE,
      ST_DONE
   } cfra_state_type;

   typedef struct packed {
      logic                   load;
      logic                   div_step;
      logic                   mul_d;
      logic                   chk_d;
      logic                   mul_n;
      logic                   update;
      logic                   out_load;
      logic [CHUNK_IDX_W-1:0] chunk;
   } cfra_cmd_type;

   typedef struct packed {
      logic exceed;
      logic stop;
   } cfra_status_type;

endpackage

>>> rtl/core/cfra_ctrl.sv
// Sequencer of the rational approximation core: handshakes, step counter and commands.
`include "assert_macros.svh"

module cfra_ctrl #(
   parameter int unsigned DIV_STEPS = 48
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cfra_pkg::cfra_cmd_type    cmd,
   input  cfra_pkg::cfra_status_type status
);
   import cfra_pkg::*;

   localparam int unsigned CW = $clog2(DIV_STEPS);

   cfra_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == CW'(DIV_STEPS - 1)) state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            state_in = ST_CHK_D;
         end
         ST_CHK_D: begin
            state_in = status.exceed ? ST_DONE : ST_MUL_N;
         end
         ST_MUL_N: begin
            if (cnt_ff == CW'(N_CHUNKS - 1)) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = status.stop ? ST_DONE : ST_DIV;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.chunk    = cnt_ff[CHUNK_IDX_W-1:0];
      case (state_ff)
         ST_IDLE:   cmd.load     = req_valid;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_MUL_D:  cmd.mul_d    = 1'b1;
         ST_CHK_D:  cmd.chk_d    = 1'b1;
         ST_MUL_N:  cmd.mul_n    = 1'b1;
         ST_UPDATE: cmd.update   = 1'b1;
         ST_DONE:   cmd.out_load = out_free;
         default:   cmd.load     = 1'b0;
      endcase
   end

   // The counter restarts whenever the state changes.
   always_comb begin
      if (state_in != state_ff) begin
         cnt_in = '0;
      end else begin
         cnt_in = cnt_ff + CW'(1);
      end
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CFRA_ASSERT_NEXT(a_load_starts_div, clock, reset, cmd.load, (state_ff == ST_DIV) && (cnt_ff == '0), "accepted beat did not start a division")
   `CFRA_ASSERT_IMP(a_chunk_in_range, clock, reset, state_ff == ST_MUL_N, cnt_ff < CW'(N_CHUNKS), "numerator slice index out of range")

endmodule

>>> rtl/core/cfra_datapath.sv
// Datapath of the rational approximation core: serial divider, convergent matrix, output register.
`include "assert_macros.svh"

module cfra_datapath #(
   parameter int unsigned FRAC_BITS = 32,
   parameter int unsigned INT_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cfra_pkg::cfra_cmd_type               cmd,
   output cfra_pkg::cfra_status_type            status,
   input  logic [cfra_pkg::DEN_W-1:0]           max_den,
   input  logic [cfra_pkg::NUM_W-1:0]           req_x_value,
   output logic [cfra_pkg::NUM_W-1:0]           rsp_numerator,
   output logic [cfra_pkg::DEN_W-1:0]           rsp_denominator
);
   import cfra_pkg::*;

   localparam int unsigned PW = INT_BITS + FRAC_BITS;   // dividend width
   localparam int unsigned QW = FRAC_BITS + 1;          // divisor width
   localparam int unsigned PPW = TERM_W + CHUNK_W;
   localparam int unsigned TLW = QW + TERM_W;

   logic [PW-1:0]      p_ff, p_in;
   logic [QW-1:0]      q_ff, q_in;
   logic [QW-1:0]      rem_ff, rem_in;
   logic [NUM_W-1:0]   n_cur_ff, n_cur_in, n_prev_ff, n_prev_in;
   logic [DEN_W-1:0]   d_cur_ff, d_cur_in, d_prev_ff, d_prev_in;
   logic [2*DEN_W-1:0] dprod_ff, dprod_in;
   logic [NUM_W-1:0]   acc_ff, acc_in;
   logic               stop_ff, stop_in;
   logic [NUM_W-1:0]   num_out_ff;
   logic [DEN_W-1:0]   den_out_ff;

   logic [DEN_W-1:0]    limit;
   logic [PW+NUM_W-1:0] x_ext;
   logic [PW+TERM_W-1:0] p_ext;
   logic [TERM_W-1:0]   term;
   logic [QW:0]         trial;
   logic [QW:0]         trial_diff;
   logic                ge;
   logic [2*DEN_W:0]    den_next;
   logic [TLW-1:0]      tl_r;
   logic [SH_W-1:0]     sh;
   logic [CHUNK_W-1:0]  slice;
   logic [PPW-1:0]      pp;
   logic [NUM_W-1:0]    pp_sh;

   assign limit = (max_den == '0) ? DEN_W'(1) : max_den;
   assign x_ext = {PW'(0), req_x_value};
   assign p_ext = {TERM_W'(0), p_ff};
   assign term  = p_ext[TERM_W-1:0];

   // One restoring division step per cycle.
   assign trial      = {rem_ff, p_ff[PW-1]};
   assign trial_diff = trial - {1'b0, q_ff};
   assign ge         = (trial >= {1'b0, q_ff});

   assign den_next = (2*DEN_W+1)'(dprod_ff) + (2*DEN_W+1)'(d_prev_ff);
   // Largest term times remainder, as (r << TERM_W) - r.
   assign tl_r     = {rem_ff, TERM_W'(0)} - TLW'(rem_ff);

   assign sh    = SH_W'(cmd.chunk) * SH_W'(CHUNK_W);
   assign slice = CHUNK_W'(n_cur_ff >> sh);
   assign pp    = PPW'(slice) * PPW'(term);
   assign pp_sh = NUM_W'(pp) << sh;

   assign status.exceed = (den_next > (2*DEN_W+1)'(limit));
   assign status.stop   = stop_ff;

   always_comb begin
      p_in      = p_ff;
      q_in      = q_ff;
      rem_in    = rem_ff;
      n_cur_in  = n_cur_ff;
      n_prev_in = n_prev_ff;
      d_cur_in  = d_cur_ff;
      d_prev_in = d_prev_ff;
      dprod_in  = dprod_ff;
      acc_in    = acc_ff;
      stop_in   = stop_ff;
      if (cmd.load) begin
         p_in      = x_ext[PW-1:0];
         q_in      = {1'b1, FRAC_BITS'(0)};
         rem_in    = '0;
         n_cur_in  = NUM_W'(1);
         n_prev_in = '0;
         d_cur_in  = '0;
         d_prev_in = DEN_W'(1);
      end
      if (cmd.div_step) begin
         p_in   = {p_ff[PW-2:0], ge};
         rem_in = ge ? trial_diff[QW-1:0] : trial[QW-1:0];
      end
      if (cmd.mul_d) begin
         dprod_in = (2*DEN_W)'(d_cur_ff) * (2*DEN_W)'(term);
         acc_in   = '0;
      end
      if (cmd.chk_d) begin
         // A zero remainder also lands here, as tl_r is then zero.
         stop_in = (TLW'(q_ff) > tl_r);
      end
      if (cmd.mul_n) begin
         acc_in = acc_ff + pp_sh;
      end
      if (cmd.update) begin
         n_prev_in = n_cur_ff;
         n_cur_in  = acc_ff + n_prev_ff;
         d_prev_in = d_cur_ff;
         d_cur_in  = den_next[DEN_W-1:0];
         p_in      = PW'(q_ff);
         q_in      = rem_ff;
         rem_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      q_ff      <= q_in;
      rem_ff    <= rem_in;
      n_cur_ff  <= n_cur_in;
      n_prev_ff <= n_prev_in;
      d_cur_ff  <= d_cur_in;
      d_prev_ff <= d_prev_in;
      dprod_ff  <= dprod_in;
      acc_ff    <= acc_in;
      stop_ff   <= stop_in;
      if (cmd.out_load) begin
         num_out_ff <= n_cur_ff;
         den_out_ff <= d_cur_ff;
      end
   end

   assign rsp_numerator   = num_out_ff;
   assign rsp_denominator = den_out_ff;

   `CFRA_ASSERT_NEXT(a_rem_below_divisor, clock, reset, cmd.div_step, rem_ff < q_ff, "division remainder not below divisor")
   `CFRA_ASSERT_NEXT(a_den_within_limit, clock, reset, cmd.update, d_cur_ff <= limit, "denominator exceeds the limit")

endmodule

>>> rtl/core/continued_fraction_rational_approx_core.sv
// Top level of the continued-fraction best rational approximation core.
// Each applied term runs the serial division, the denominator product and limit check, the
// numerator product in slices and the matrix update; a rejected last term ends after the limit
// check. rsp_valid rises as the result enters the output register; division yields one bit per cycle.
// Throughput: one item in flight; the next beat is taken once the result is in the output register.
// Reset (synchronous, active high) idles the sequencer, empties the output and sets the limit to 10000.

module continued_fraction_rational_approx_core #(
   parameter int unsigned FRAC_BITS = 32,
   parameter int unsigned INT_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [cfra_pkg::NUM_W-1:0]     req_x_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [cfra_pkg::NUM_W-1:0]     rsp_numerator,
   output logic [cfra_pkg::DEN_W-1:0]     rsp_denominator,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cfra_pkg::DEN_W-1:0]     csr_max_denominator
);
   import cfra_pkg::*;

   // The limit register. Writes are expected only while the core is idle, so the
   // register is always open to a beat.
   logic [DEN_W-1:0] max_den_ff, max_den_in;

   cfra_cmd_type    cmd;
   cfra_status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      if (csr_valid && csr_ready) begin
         max_den_in = csr_max_denominator;
      end else begin
         max_den_in = max_den_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_den_ff <= DEN_RESET;
      end else begin
         max_den_ff <= max_den_in;
      end
   end

   // The sequencer walks the Euclid steps: a full-width serial division for the
   // term, the denominator product and limit check, then the numerator product
   // in slices and the matrix update.
   cfra_ctrl #(
      .DIV_STEPS (INT_BITS + FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the divider, the convergent matrix and the output register.
   cfra_datapath #(
      .FRAC_BITS (FRAC_BITS),
      .INT_BITS  (INT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .max_den         (max_den_ff),
      .req_x_value     (req_x_value),
      .rsp_numerator   (rsp_numerator),
      .rsp_denominator (rsp_denominator)
   );

endmodule

>>> tb/cfra_result_checker.sv
// Channel monitor, result predictor and comparator for the rational approximation core.
module cfra_result_checker #(
   parameter int unsigned FRAC_BITS = 32,
   parameter int unsigned INT_BITS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [cfra_pkg::NUM_W-1:0] req_x_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [cfra_pkg::NUM_W-1:0] rsp_numerator,
   input  logic [cfra_pkg::DEN_W-1:0] rsp_denominator,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [cfra_pkg::DEN_W-1:0] csr_max_denominator,
   output int                         fail_count,
   output int                         pending,
   output int                         results_checked
);
   import cfra_pkg::*;

   typedef struct {
      logic [NUM_W-1:0] x_value;
      logic [NUM_W-1:0] numerator;
      logic [DEN_W-1:0] denominator;
   } fraction_type;

   localparam logic [63:0] TERM_MAX = (64'd1 << TERM_W) - 64'd1;

   fraction_type     expected_fractions[$];
   logic [DEN_W-1:0] max_den = DEN_RESET;
   int               mismatches = 0;
   int               checked = 0;

   // Walks the continued-fraction expansion of x / 2^FRAC_BITS with exact Euclid steps and
   // keeps the last convergent with denominator within the limit; a term above TERM_MAX stops it.
   function automatic fraction_type best_convergent(input logic [NUM_W-1:0] x,
                                                    input logic [DEN_W-1:0] lim);
      fraction_type result;
      logic [63:0]  dividend, divisor, bound, term, rem, next;
      logic [63:0]  n_cur, n_prev, d_cur, d_prev;
      dividend = 64'(x) & ((64'd1 << (INT_BITS + FRAC_BITS)) - 64'd1);
      divisor  = 64'd1 << FRAC_BITS;
      bound    = (lim == '0) ? 64'd1 : 64'(lim);
      n_cur    = 64'd1;
      n_prev   = 64'd0;
      d_cur    = 64'd0;
      d_prev   = 64'd1;
      while (1) begin
         term = dividend / divisor;
         rem  = dividend - term * divisor;
         if (d_cur * term + d_prev > bound) break;
         next   = n_cur * term + n_prev;
         n_prev = n_cur;
         n_cur  = next;
         next   = d_cur * term + d_prev;
         d_prev = d_cur;
         d_cur  = next;
         if (rem == 64'd0) break;
         if (divisor > TERM_MAX * rem) break;
         dividend = divisor;
         divisor  = rem;
      end
      result.x_value     = x;
      result.numerator   = n_cur[NUM_W-1:0];
      result.denominator = d_cur[DEN_W-1:0];
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      fraction_type want;
      if (reset) begin
         max_den = DEN_RESET;
         expected_fractions.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            checked++;
            if (expected_fractions.size() == 0) begin
               report_mismatch($sformatf("result %0d/%0d with nothing outstanding",
                                         rsp_numerator, rsp_denominator));
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_numerator !== want.numerator)
                  report_mismatch($sformatf("x=%h numerator %0d, expected %0d",
                                            want.x_value, rsp_numerator, want.numerator));
               if (rsp_denominator !== want.denominator)
                  report_mismatch($sformatf("x=%h denominator %0d, expected %0d",
                                            want.x_value, rsp_denominator, want.denominator));
            end
         end
         if (csr_valid === 1'b1 && csr_ready === 1'b1)
            max_den = csr_max_denominator;
         if (req_valid === 1'b1 && req_stall === 1'b0)
            expected_fractions.push_back(best_convergent(req_x_value, max_den));
      end
      fail_count      <= mismatches;
      pending         <= expected_fractions.size();
      results_checked <= checked;
   end

endmodule

>>> tb/tb_continued_fraction_rational_approx_core.sv
// Stimulus and verdict for the continued-fraction rational approximation core.
module tb_continued_fraction_rational_approx_core;
   import cfra_pkg::*;

   localparam int unsigned FRAC_BITS       = 32;
   localparam int unsigned INT_BITS        = 16;
   // The receiver's long hold-off must outlast more than one item at the default limit, so
   // that the output register fills, the next item completes and the input backs up.
   localparam int unsigned HOLD_OFF_CYCLES = 6000;
   // After the last result the core is given a full worst-case item time to misbehave.
   localparam int unsigned TAIL_CYCLES     = 3000;
   localparam int unsigned PHASE_ITEMS     = 30;
   localparam logic [DEN_W-1:0] DEN_MAX    = '1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [NUM_W-1:0] req_x_value = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [NUM_W-1:0] rsp_numerator;
   logic [DEN_W-1:0] rsp_denominator;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [DEN_W-1:0] csr_max_denominator = DEN_RESET;

   // Control shared between the sender and the receiver processes, and the receiver's own flag.
   logic             calm = 1'b0;
   logic             hold_off_request = 1'b0;
   logic             hold_off_done = 1'b0;

   int               fail_count;
   int               pending;
   int               results_checked;
   int               limits_written = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   continued_fraction_rational_approx_core #(
      .FRAC_BITS (FRAC_BITS),
      .INT_BITS  (INT_BITS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_x_value         (req_x_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_numerator       (rsp_numerator),
      .rsp_denominator     (rsp_denominator),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_denominator (csr_max_denominator)
   );

   cfra_result_checker #(
      .FRAC_BITS (FRAC_BITS),
      .INT_BITS  (INT_BITS)
   ) result_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_x_value         (req_x_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_numerator       (rsp_numerator),
      .rsp_denominator     (rsp_denominator),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_denominator (csr_max_denominator),
      .fail_count          (fail_count),
      .pending             (pending),
      .results_checked     (results_checked)
   );

   // Random values are drawn from several shapes. Fully random values give long expansions,
   // integers and values with many trailing zeros end early on an exact remainder, and values
   // close to small ratios produce one very large term that trips the term limit.
   function automatic logic [NUM_W-1:0] random_value();
      logic [63:0]      wide;
      logic [NUM_W-1:0] value;
      int unsigned      shift, p, q;
      wide = {16'h0, 16'($urandom), 32'($urandom)};
      case ($urandom_range(0, 5))
         0: value = wide[NUM_W-1:0];
         1: value = NUM_W'($urandom_range(0, 1 << 20));
         2: value = {wide[47:32], 32'h0};
         3: begin
            shift = $urandom_range(1, 44);
            value = NUM_W'((wide >> shift) << shift);
         end
         4: begin
            p     = $urandom_range(1, 200);
            q     = $urandom_range(1, 200);
            value = NUM_W'(((64'(p) << FRAC_BITS) / q) + 64'($urandom_range(0, 2)));
         end
         default: value = {16'hFFFF, 32'($urandom)} | wide[NUM_W-1:0];
      endcase
      return value;
   endfunction

   // Offers one beat, idling beforehand now and then, and returns at the edge that takes it.
   // The payload is held steady for as long as the core stalls.
   task automatic send_value(input logic [NUM_W-1:0] x);
      while (!calm && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_value <= x;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // Drops valid and waits until every expected result has come back. The extra edge lets
   // the checker's count settle after the last beat was taken.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Only ever called with the core idle.
   task automatic write_limit(input logic [DEN_W-1:0] value);
      csr_valid           <= 1'b1;
      csr_max_denominator <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      limits_written++;
   endtask

   // The receiver stalls at random, never in a calm phase, and once holds off for a long,
   // counted stretch so that a finished result sits in the output register while the
   // sender keeps offering beats.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_off_request && !hold_off_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall     <= 1'b0;
            hold_off_done <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 17);
         end
      end
   end

   initial begin : stimulus
      logic [NUM_W-1:0] landmarks [14];
      logic [DEN_W-1:0] phase_limit;
      // Zero, the largest value, the smallest steps, exact integers and a half, values just
      // below one and with only the top bit set, and a few well-known irrationals whose
      // expansions run long.
      landmarks = '{48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0001,
                    48'h0000_0000_0002, 48'h0000_0000_0003, 48'h0001_0000_0000,
                    48'h0000_8000_0000, 48'h0000_FFFF_FFFF, 48'hFFFF_0000_0000,
                    48'h8000_0000_0000, 48'h0003_243F_6A88, 48'h0001_9E37_79B9,
                    48'h0001_6A09_E667, 48'h0002_B7E1_5162};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The first phase runs on the limit left by reset, without any write.
      foreach (landmarks[i]) send_value(landmarks[i]);
      drain;

      // A zero limit must behave as a limit of one, giving the nearest integer (a half rounds down) over one.
      write_limit('0);
      send_value(landmarks[10]);
      send_value(landmarks[1]);
      send_value(landmarks[11]);
      drain;

      // Random phases, each on a limit written at its start. One phase runs with no idling on either side
      // and another carries the long output hold-off.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       phase_limit = DEN_W'(1);
            1:       phase_limit = DEN_MAX;
            2:       phase_limit = DEN_W'($urandom_range(2, 100));
            3:       phase_limit = '0;
            4:       phase_limit = DEN_RESET;
            5:       phase_limit = DEN_W'($urandom_range(1, 32'h7FFF_FFFF));
            6:       phase_limit = DEN_W'($urandom_range(101, 65535));
            default: phase_limit = DEN_MAX;
         endcase
         write_limit(phase_limit);
         calm <= (phase == 1);
         if (phase == 4) hold_off_request <= 1'b1;
         repeat (PHASE_ITEMS) send_value(random_value());
         drain;
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Checked %0d approximations across %0d limit writes, from zero and one up to",
               results_checked, limits_written);
      $display("the 31-bit maximum, with random idling and one long output hold-off.");
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Generous watchdog: far beyond 257 items at their longest expansion plus every stall.
   initial begin : watchdog
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/cfra_pkg.sv
rtl/core/cfra_ctrl.sv
rtl/core/cfra_datapath.sv
rtl/core/continued_fraction_rational_approx_core.sv
tb/cfra_result_checker.sv
tb/tb_continued_fraction_rational_approx_core.sv
